// ===== rtl/lac_pkg.sv =====
package lac_pkg;

    // Widths of the datapath
    localparam int VEC_W      = 33;  // direction components, one bit past the inputs
    localparam int LZ_W       = 6;   // leading-one position over VEC_W bits
    localparam int MANT_W     = 30;  // normalized component magnitude
    localparam int MANT_MSB   = 29;
    localparam int SQ_W       = 2 * MANT_W;
    localparam int UNIT_W     = 32;  // Q2.30 word
    localparam int SQRT_NW    = 64;  // radicand width
    localparam int ROOT_W     = SQRT_NW / 2 + 1;
    localparam int DEN_W      = 32;
    localparam int NORM_QW    = 31;  // unit quotient never exceeds 2^30
    localparam int QUAT_QW    = 33;  // larger quotients saturate
    localparam int FRAC_W     = 30;
    localparam int PROD_W     = 64;

    localparam logic [UNIT_W-1:0] Q30_ONE = 32'h4000_0000;
    localparam logic [UNIT_W-1:0] Q30_NEG_ONE = 32'hC000_0000;
    localparam logic [UNIT_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [UNIT_W-1:0] S32_MIN = 32'h8000_0000;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// ===== rtl/lac_if.sv =====
interface lac_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] forward_x;
    logic [31:0] forward_y;
    logic [31:0] forward_z;
    logic [31:0] src_x;
    logic [31:0] src_y;
    logic [31:0] src_z;
    logic [31:0] dest_x;
    logic [31:0] dest_y;
    logic [31:0] dest_z;

    modport source (
        output valid, forward_x, forward_y, forward_z, src_x, src_y, src_z,
               dest_x, dest_y, dest_z,
        input  ready
    );
    modport sink (
        input  valid, forward_x, forward_y, forward_z, src_x, src_y, src_z,
               dest_x, dest_y, dest_z,
        output ready
    );
endinterface

interface lac_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] quat_x;
    logic [31:0] quat_y;
    logic [31:0] quat_z;
    logic [31:0] quat_w;
    logic [31:0] dot_product;
    logic        degenerate;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, dot_product, degenerate,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, dot_product, degenerate,
        output ready
    );
endinterface

// ===== rtl/lac_isqrt.sv =====
module lac_isqrt #(
    parameter int NW = 64,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lac_pkg::t_pipe_ctl i_ctl,
    input  logic [NW-1:0]      i_n,
    input  logic [SW-1:0]      i_sb,
    output logic               o_valid,
    output logic [NW/2:0]      o_root,
    output logic [SW-1:0]      o_sb
);
    localparam int RB = NW / 2;

    logic [RB+1:0] r_rem  [RB];
    logic [RB-1:0] r_root [RB];
    logic [NW-1:0] r_n    [RB];
    logic [SW-1:0] r_sb   [RB];
    logic [RB-1:0] r_v;

    logic [NW/2:0] r_out_root;
    logic [SW-1:0] r_out_sb;
    logic          r_out_v;

    for (genvar k = 0; k < RB; k++) begin : g_step
        logic [RB+1:0] rem_in;
        logic [RB-1:0] root_in;
        logic [NW-1:0] n_in;
        logic [SW-1:0] sb_in;
        logic          v_in;
        logic [RB+2:0] acc;
        logic [RB+2:0] trial_sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = i_n;
            assign sb_in   = i_sb;
            assign v_in    = i_ctl.valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign n_in    = r_n[k-1];
            assign sb_in   = r_sb[k-1];
            assign v_in    = r_v[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign acc       = {rem_in[RB:0], n_in[NW-1-2*k -: 2]};
        assign trial_sub = {1'b0, root_in, 2'b01};
        assign ge        = (acc >= trial_sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= ge ? (acc[RB+1:0] - trial_sub[RB+1:0]) : acc[RB+1:0];
                r_root[k] <= {root_in[RB-2:0], ge};
                r_n[k]    <= n_in;
                r_sb[k]   <= sb_in;
            end
        end
    end

    // round to nearest: bump when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_out_v <= r_v[RB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_out_root <= {1'b0, r_root[RB-1]}
                        + (NW/2+1)'(r_rem[RB-1] > {2'b00, r_root[RB-1]});
            r_out_sb   <= r_sb[RB-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_root  = r_out_root;
    assign o_sb    = r_out_sb;
endmodule

// ===== rtl/lac_div.sv =====
module lac_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 33,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lac_pkg::t_pipe_ctl i_ctl,
    input  logic [NW-1:0]      i_num,
    input  logic [DW-1:0]      i_den,
    input  logic [SW-1:0]      i_sb,
    output logic               o_valid,
    output logic [QW-1:0]      o_quot,
    output logic               o_ovf,
    output logic [SW-1:0]      o_sb
);
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [QW-1:0] r_num  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_sb   [QW];
    logic [QW-1:0] r_ovf;
    logic [QW-1:0] r_v;

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quot_in;
        logic [QW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] sb_in;
        logic          ovf_in;
        logic          v_in;
        logic [DW:0]   acc;
        logic          ge;

        if (k == 0) begin : g_first
            logic [NW-QW-1:0] hi;
            assign hi      = i_num[NW-1:QW];
            // upper part at or above the divisor means the quotient needs more than QW bits
            assign ovf_in  = (hi >= i_den);
            assign rem_in  = DW'(hi);
            assign quot_in = '0;
            assign num_in  = i_num[QW-1:0];
            assign den_in  = i_den;
            assign sb_in   = i_sb;
            assign v_in    = i_ctl.valid;
        end else begin : g_next
            assign ovf_in  = r_ovf[k-1];
            assign rem_in  = r_rem[k-1];
            assign quot_in = r_quot[k-1];
            assign num_in  = r_num[k-1];
            assign den_in  = r_den[k-1];
            assign sb_in   = r_sb[k-1];
            assign v_in    = r_v[k-1];
        end

        assign acc = {rem_in, num_in[QW-1-k]};
        assign ge  = (acc >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k]  <= ge ? DW'(acc - {1'b0, den_in}) : acc[DW-1:0];
                r_quot[k] <= {quot_in[QW-2:0], ge};
                r_num[k]  <= num_in;
                r_den[k]  <= den_in;
                r_sb[k]   <= sb_in;
                r_ovf[k]  <= ovf_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_ovf   = r_ovf[QW-1];
    assign o_sb    = r_sb[QW-1];
endmodule

// ===== rtl/lac_norm.sv =====
module lac_norm #(
    parameter int SW = 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lac_pkg::t_pipe_ctl                   i_ctl,
    input  logic [2:0][lac_pkg::VEC_W-1:0]       i_vec,
    input  logic [SW-1:0]                        i_sb,
    output logic                                 o_valid,
    output logic [2:0][lac_pkg::UNIT_W-1:0]      o_unit,
    output logic                                 o_zero,
    output logic [SW-1:0]                        o_sb
);
    localparam int VW   = lac_pkg::VEC_W;
    localparam int MW   = lac_pkg::MANT_W;
    localparam int ISW  = SW + 1 + 3 + 3 * MW;
    localparam int D0SW = SW + 2;

    lac_pkg::t_pipe_ctl ctl_sq;
    lac_pkg::t_pipe_ctl ctl_dv;

    // stage A: magnitudes and largest magnitude
    logic [2:0][VW-1:0] a_mag;
    logic [2:0]         a_neg;
    logic [VW-1:0]      a_max;
    logic [2:0][VW-1:0] r_a_mag;
    logic [2:0]         r_a_neg;
    logic [VW-1:0]      r_a_max;
    logic [SW-1:0]      r_a_sb;
    logic               r_a_v;

    always_comb begin
        a_max = '0;
        for (int i = 0; i < 3; i++) begin
            a_neg[i] = i_vec[i][VW-1];
            a_mag[i] = a_neg[i] ? (~i_vec[i] + VW'(1)) : i_vec[i];
            if (a_mag[i] > a_max) begin
                a_max = a_mag[i];
            end
        end
    end

    // stage B: leading-one position
    logic [lac_pkg::LZ_W-1:0] b_p;
    logic [2:0][VW-1:0]       r_b_mag;
    logic [2:0]               r_b_neg;
    logic [lac_pkg::LZ_W-1:0] r_b_p;
    logic                     r_b_zero;
    logic [SW-1:0]            r_b_sb;
    logic                     r_b_v;

    always_comb begin
        b_p = '0;
        for (int j = 0; j < VW; j++) begin
            if (r_a_max[j]) begin
                b_p = lac_pkg::LZ_W'(j);
            end
        end
    end

    // stage C: scale so the largest magnitude lands in [2^29, 2^30)
    logic [2:0][MW-1:0] c_m;
    logic [2:0][MW-1:0] r_c_m;
    logic [2:0]         r_c_neg;
    logic               r_c_zero;
    logic [SW-1:0]      r_c_sb;
    logic               r_c_v;

    always_comb begin
        logic [VW+MW-1:0] wide;
        for (int i = 0; i < 3; i++) begin
            wide = {{MW{1'b0}}, r_b_mag[i]};
            if (r_b_p > lac_pkg::LZ_W'(lac_pkg::MANT_MSB)) begin
                wide = wide >> (r_b_p - lac_pkg::LZ_W'(lac_pkg::MANT_MSB));
            end else begin
                wide = wide << (lac_pkg::LZ_W'(lac_pkg::MANT_MSB) - r_b_p);
            end
            c_m[i] = wide[MW-1:0];
        end
    end

    // stage D: squares
    logic [2:0][lac_pkg::SQ_W-1:0] r_d_sq;
    logic [2:0][MW-1:0]            r_d_m;
    logic [2:0]                    r_d_neg;
    logic                          r_d_zero;
    logic [SW-1:0]                 r_d_sb;
    logic                          r_d_v;

    // stage E: sum of squares
    logic [lac_pkg::SQRT_NW-1:0] r_e_sum;
    logic [2:0][MW-1:0]          r_e_m;
    logic [2:0]                  r_e_neg;
    logic                        r_e_zero;
    logic [SW-1:0]               r_e_sb;
    logic                        r_e_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_a_v <= i_ctl.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_a_mag  <= a_mag;
            r_a_neg  <= a_neg;
            r_a_max  <= a_max;
            r_a_sb   <= i_sb;
            r_b_mag  <= r_a_mag;
            r_b_neg  <= r_a_neg;
            r_b_p    <= b_p;
            r_b_zero <= (r_a_max == '0);
            r_b_sb   <= r_a_sb;
            r_c_m    <= c_m;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_c_sb   <= r_b_sb;
            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= r_c_m[i] * r_c_m[i];
            end
            r_d_m    <= r_c_m;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
            r_d_sb   <= r_c_sb;
            r_e_sum  <= lac_pkg::SQRT_NW'(r_d_sq[0]) + lac_pkg::SQRT_NW'(r_d_sq[1])
                      + lac_pkg::SQRT_NW'(r_d_sq[2]);
            r_e_m    <= r_d_m;
            r_e_neg  <= r_d_neg;
            r_e_zero <= r_d_zero;
            r_e_sb   <= r_d_sb;
        end
    end

    // vector length
    logic                        sq_v;
    logic [lac_pkg::ROOT_W-1:0]  sq_len;
    logic [ISW-1:0]              sq_sb;
    logic [SW-1:0]               sq_osb;
    logic                        sq_zero;
    logic [2:0]                  sq_neg;
    logic [2:0][MW-1:0]          sq_m;

    assign ctl_sq = '{en: i_ctl.en, valid: r_e_v};

    lac_isqrt #(
        .NW (lac_pkg::SQRT_NW),
        .SW (ISW)
    ) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sq),
        .i_n     (r_e_sum),
        .i_sb    ({r_e_sb, r_e_zero, r_e_neg, r_e_m}),
        .o_valid (sq_v),
        .o_root  (sq_len),
        .o_sb    (sq_sb)
    );

    assign {sq_osb, sq_zero, sq_neg, sq_m} = sq_sb;

    // stage F: dividend with half the divisor for round to nearest
    logic [2:0][lac_pkg::SQRT_NW-1:0] r_f_num;
    logic [lac_pkg::DEN_W-1:0]        r_f_len;
    logic [2:0]                       r_f_neg;
    logic                             r_f_zero;
    logic [SW-1:0]                    r_f_sb;
    logic                             r_f_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_f_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_num[i] <= (lac_pkg::SQRT_NW'(sq_m[i]) << lac_pkg::FRAC_W)
                            + lac_pkg::SQRT_NW'(sq_len >> 1);
            end
            r_f_len  <= sq_len[lac_pkg::DEN_W-1:0];
            r_f_neg  <= sq_neg;
            r_f_zero <= sq_zero;
            r_f_sb   <= sq_osb;
        end
    end

    assign ctl_dv = '{en: i_ctl.en, valid: r_f_v};

    logic [2:0]                          dv_v;
    logic [2:0][lac_pkg::NORM_QW-1:0]    dv_q;
    logic [D0SW-1:0]                     dv0_sb;
    logic [2:1]                          dv_neg;

    lac_div #(
        .NW (lac_pkg::SQRT_NW),
        .DW (lac_pkg::DEN_W),
        .QW (lac_pkg::NORM_QW),
        .SW (D0SW)
    ) u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_dv),
        .i_num   (r_f_num[0]),
        .i_den   (r_f_len),
        .i_sb    ({r_f_sb, r_f_zero, r_f_neg[0]}),
        .o_valid (dv_v[0]),
        .o_quot  (dv_q[0]),
        .o_ovf   (),
        .o_sb    (dv0_sb)
    );

    for (genvar i = 1; i < 3; i++) begin : g_lane
        lac_div #(
            .NW (lac_pkg::SQRT_NW),
            .DW (lac_pkg::DEN_W),
            .QW (lac_pkg::NORM_QW),
            .SW (1)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_dv),
            .i_num   (r_f_num[i]),
            .i_den   (r_f_len),
            .i_sb    (r_f_neg[i]),
            .o_valid (dv_v[i]),
            .o_quot  (dv_q[i]),
            .o_ovf   (),
            .o_sb    (dv_neg[i])
        );
    end

    // stage G: restore signs
    logic [2:0]                       g_neg;
    logic [2:0][lac_pkg::UNIT_W-1:0]  r_g_unit;
    logic                             r_g_zero;
    logic [SW-1:0]                    r_g_sb;
    logic                             r_g_v;

    assign g_neg = {dv_neg[2], dv_neg[1], dv0_sb[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (i_ctl.en) begin
            r_g_v <= &dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_g_unit[i] <= g_neg[i] ? (lac_pkg::UNIT_W'(0) - lac_pkg::UNIT_W'(dv_q[i]))
                                        : lac_pkg::UNIT_W'(dv_q[i]);
            end
            r_g_zero <= dv0_sb[1];
            r_g_sb   <= dv0_sb[D0SW-1:2];
        end
    end

    assign o_valid = r_g_v;
    assign o_unit  = r_g_unit;
    assign o_zero  = r_g_zero;
    assign o_sb    = r_g_sb;
endmodule

// ===== rtl/look_at_shortest_arc_quaternion_core.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Depth is set by the two bit-serial square roots (33 stages each) and the
// two restoring dividers (31 and 33 stages).
// Reset (synchronous, active low) clears every valid bit; data registers keep.
module look_at_shortest_arc_quaternion_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lac_in_if.sink          i_in,
    lac_out_if.source       o_out
);
    localparam int VW  = lac_pkg::VEC_W;
    localparam int UW  = lac_pkg::UNIT_W;
    localparam int PW  = lac_pkg::PROD_W;
    localparam int NW  = lac_pkg::SQRT_NW;
    localparam int SSW = 1 + UW + 3 + 3 * UW;
    localparam int D0W = 1 + 1 + UW + UW + 1;

    logic               en;
    lac_pkg::t_pipe_ctl ctl_in;
    logic               r_out_v;

    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;

    // stage 0: forward vector and direction at 33 bits
    logic [2:0][VW-1:0] r_s0_fwd;
    logic [2:0][VW-1:0] r_s0_dir;
    logic               r_s0_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_fwd[0] <= VW'($signed(i_in.forward_x));
            r_s0_fwd[1] <= VW'($signed(i_in.forward_y));
            r_s0_fwd[2] <= VW'($signed(i_in.forward_z));
            r_s0_dir[0] <= VW'($signed(i_in.dest_x)) - VW'($signed(i_in.src_x));
            r_s0_dir[1] <= VW'($signed(i_in.dest_y)) - VW'($signed(i_in.src_y));
            r_s0_dir[2] <= VW'($signed(i_in.dest_z)) - VW'($signed(i_in.src_z));
        end
    end

    assign ctl_in = '{en: en, valid: r_s0_v};

    logic               nf_v;
    logic               nd_v;
    logic [2:0][UW-1:0] uf;
    logic [2:0][UW-1:0] ud;
    logic               nf_zero;
    logic               nd_zero;
    logic               nf_sb;
    logic               nd_sb;

    lac_norm #(.SW(1)) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_vec   (r_s0_fwd),
        .i_sb    (1'b0),
        .o_valid (nf_v),
        .o_unit  (uf),
        .o_zero  (nf_zero),
        .o_sb    (nf_sb)
    );

    lac_norm #(.SW(1)) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_vec   (r_s0_dir),
        .i_sb    (1'b0),
        .o_valid (nd_v),
        .o_unit  (ud),
        .o_zero  (nd_zero),
        .o_sb    (nd_sb)
    );

    // stage T1: products at Q4.60
    logic [8:0][PW-1:0] r_t1_p;
    logic               r_t1_degen;
    logic               r_t1_v;

    // stage T2: cross components and dot sum
    logic [3:0][PW-1:0] r_t2_sum;
    logic               r_t2_degen;
    logic               r_t2_v;

    // stage T3: back to Q2.30, rounded half away from zero
    logic [3:0][PW-1:0] t3_mag;
    logic [3:0][PW-1:0] t3_rnd;
    logic [2:0][UW-1:0] r_t3_amag;
    logic [2:0]         r_t3_aneg;
    logic [34:0]        r_t3_d;
    logic               r_t3_degen;
    logic               r_t3_v;

    // stage T4: clamp and radicand 2 * (1 + d) at Q4.60
    logic [UW-1:0]      t4_d;
    logic [UW:0]        t4_opd;
    logic [NW-1:0]      r_t4_arg;
    logic [UW-1:0]      r_t4_d;
    logic [2:0][UW-1:0] r_t4_amag;
    logic [2:0]         r_t4_aneg;
    logic               r_t4_degen;
    logic               r_t4_v;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t3_mag[i] = r_t2_sum[i][PW-1] ? (PW'(0) - r_t2_sum[i]) : r_t2_sum[i];
            t3_rnd[i] = (t3_mag[i] + (PW'(1) << (lac_pkg::FRAC_W - 1))) >> lac_pkg::FRAC_W;
        end
    end

    always_comb begin
        if ($signed(r_t3_d) > $signed(35'(lac_pkg::Q30_ONE))) begin
            t4_d = lac_pkg::Q30_ONE;
        end else if ($signed(r_t3_d) < -$signed(35'(lac_pkg::Q30_ONE))) begin
            t4_d = lac_pkg::Q30_NEG_ONE;
        end else begin
            t4_d = r_t3_d[UW-1:0];
        end
        t4_opd = (UW+1)'($signed(t4_d)) + (UW+1)'(lac_pkg::Q30_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else if (en) begin
            r_t1_v <= nf_v && nd_v;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1_p[0] <= PW'($signed(uf[1]) * $signed(ud[2]));
            r_t1_p[1] <= PW'($signed(uf[2]) * $signed(ud[1]));
            r_t1_p[2] <= PW'($signed(uf[2]) * $signed(ud[0]));
            r_t1_p[3] <= PW'($signed(uf[0]) * $signed(ud[2]));
            r_t1_p[4] <= PW'($signed(uf[0]) * $signed(ud[1]));
            r_t1_p[5] <= PW'($signed(uf[1]) * $signed(ud[0]));
            r_t1_p[6] <= PW'($signed(uf[0]) * $signed(ud[0]));
            r_t1_p[7] <= PW'($signed(uf[1]) * $signed(ud[1]));
            r_t1_p[8] <= PW'($signed(uf[2]) * $signed(ud[2]));
            r_t1_degen <= nf_zero || nd_zero || nf_sb || nd_sb;

            r_t2_sum[0] <= r_t1_p[0] - r_t1_p[1];
            r_t2_sum[1] <= r_t1_p[2] - r_t1_p[3];
            r_t2_sum[2] <= r_t1_p[4] - r_t1_p[5];
            r_t2_sum[3] <= r_t1_p[6] + r_t1_p[7] + r_t1_p[8];
            r_t2_degen  <= r_t1_degen;

            for (int i = 0; i < 3; i++) begin
                r_t3_amag[i] <= t3_rnd[i][UW-1:0];
                r_t3_aneg[i] <= r_t2_sum[i][PW-1];
            end
            r_t3_d     <= r_t2_sum[3][PW-1] ? (35'(0) - t3_rnd[3][34:0]) : t3_rnd[3][34:0];
            r_t3_degen <= r_t2_degen;

            r_t4_arg   <= NW'(t4_opd) << (lac_pkg::FRAC_W + 1);
            r_t4_d     <= t4_d;
            r_t4_amag  <= r_t3_amag;
            r_t4_aneg  <= r_t3_aneg;
            r_t4_degen <= r_t3_degen;
        end
    end

    // s = sqrt(2 * (1 + d))
    lac_pkg::t_pipe_ctl         ctl_sq;
    logic                       sq_v;
    logic [lac_pkg::ROOT_W-1:0] sq_s;
    logic [SSW-1:0]             sq_sb;
    logic                       sq_degen;
    logic [UW-1:0]              sq_d;
    logic [2:0]                 sq_aneg;
    logic [2:0][UW-1:0]         sq_amag;

    assign ctl_sq = '{en: en, valid: r_t4_v};

    lac_isqrt #(
        .NW (NW),
        .SW (SSW)
    ) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_sq),
        .i_n     (r_t4_arg),
        .i_sb    ({r_t4_degen, r_t4_d, r_t4_aneg, r_t4_amag}),
        .o_valid (sq_v),
        .o_root  (sq_s),
        .o_sb    (sq_sb)
    );

    assign {sq_degen, sq_d, sq_aneg, sq_amag} = sq_sb;

    // stage T5: dividends, s / 2 rounded half up
    logic [2:0][NW-1:0]        r_t5_num;
    logic [lac_pkg::DEN_W-1:0] r_t5_s;
    logic [UW-1:0]             r_t5_w;
    logic                      r_t5_szero;
    logic [UW-1:0]             r_t5_d;
    logic [2:0]                r_t5_aneg;
    logic                      r_t5_degen;
    logic                      r_t5_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t5_v <= 1'b0;
        end else if (en) begin
            r_t5_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_t5_num[i] <= (NW'(sq_amag[i]) << lac_pkg::FRAC_W) + NW'(sq_s >> 1);
            end
            r_t5_s     <= sq_s[lac_pkg::DEN_W-1:0];
            r_t5_w     <= UW'(((lac_pkg::ROOT_W+1)'(sq_s) + (lac_pkg::ROOT_W+1)'(1)) >> 1);
            r_t5_szero <= (sq_s == '0);
            r_t5_d     <= sq_d;
            r_t5_aneg  <= sq_aneg;
            r_t5_degen <= sq_degen;
        end
    end

    lac_pkg::t_pipe_ctl                ctl_dv;
    logic [2:0]                        dv_v;
    logic [2:0][lac_pkg::QUAT_QW-1:0]  dv_q;
    logic [2:0]                        dv_ovf;
    logic [D0W-1:0]                    dv0_sb;
    logic [2:1]                        dv_neg;
    logic                              dv_degen;
    logic                              dv_szero;
    logic [UW-1:0]                     dv_d;
    logic [UW-1:0]                     dv_w;
    logic [2:0]                        dv_aneg;

    assign ctl_dv = '{en: en, valid: r_t5_v};

    lac_div #(
        .NW (NW),
        .DW (lac_pkg::DEN_W),
        .QW (lac_pkg::QUAT_QW),
        .SW (D0W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_dv),
        .i_num   (r_t5_num[0]),
        .i_den   (r_t5_s),
        .i_sb    ({r_t5_degen, r_t5_szero, r_t5_d, r_t5_w, r_t5_aneg[0]}),
        .o_valid (dv_v[0]),
        .o_quot  (dv_q[0]),
        .o_ovf   (dv_ovf[0]),
        .o_sb    (dv0_sb)
    );

    for (genvar i = 1; i < 3; i++) begin : g_quat
        lac_div #(
            .NW (NW),
            .DW (lac_pkg::DEN_W),
            .QW (lac_pkg::QUAT_QW),
            .SW (1)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl_dv),
            .i_num   (r_t5_num[i]),
            .i_den   (r_t5_s),
            .i_sb    (r_t5_aneg[i]),
            .o_valid (dv_v[i]),
            .o_quot  (dv_q[i]),
            .o_ovf   (dv_ovf[i]),
            .o_sb    (dv_neg[i])
        );
    end

    assign {dv_degen, dv_szero, dv_d, dv_w} = dv0_sb[D0W-1:1];
    assign dv_aneg = {dv_neg[2], dv_neg[1], dv0_sb[0]};

    // output stage: saturate, sign, identity override
    logic [2:0][UW-1:0] o_q;
    logic               ident;

    assign ident = dv_degen || dv_szero;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (ident) begin
                o_q[i] = '0;
            end else if (!dv_aneg[i]) begin
                if (dv_ovf[i] || (dv_q[i] > lac_pkg::QUAT_QW'(lac_pkg::S32_MAX))) begin
                    o_q[i] = lac_pkg::S32_MAX;
                end else begin
                    o_q[i] = dv_q[i][UW-1:0];
                end
            end else begin
                if (dv_ovf[i] || (dv_q[i] > lac_pkg::QUAT_QW'(lac_pkg::S32_MIN))) begin
                    o_q[i] = lac_pkg::S32_MIN;
                end else begin
                    o_q[i] = UW'(0) - dv_q[i][UW-1:0];
                end
            end
        end
    end

    logic [2:0][UW-1:0] r_out_q;
    logic [UW-1:0]      r_out_w;
    logic [UW-1:0]      r_out_d;
    logic               r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= &dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_q     <= o_q;
            r_out_w     <= ident ? lac_pkg::Q30_ONE : dv_w;
            r_out_d     <= dv_degen ? lac_pkg::Q30_ONE : dv_d;
            r_out_degen <= dv_degen;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.quat_x      = r_out_q[0];
    assign o_out.quat_y      = r_out_q[1];
    assign o_out.quat_z      = r_out_q[2];
    assign o_out.quat_w      = r_out_w;
    assign o_out.dot_product = r_out_d;
    assign o_out.degenerate  = r_out_degen;

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_degen |-> r_out_w == lac_pkg::Q30_ONE
            && r_out_d == lac_pkg::Q30_ONE && r_out_q[0] == '0)
        else $error("degenerate word is not the identity");

    a_dot_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> $signed(r_out_d) <= $signed(lac_pkg::Q30_ONE)
            && $signed(r_out_d) >= $signed(lac_pkg::Q30_NEG_ONE))
        else $error("dot product outside [-1, 1]");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> $signed(r_out_w) >= 0 && $signed(r_out_w) <= $signed(lac_pkg::Q30_ONE))
        else $error("quat_w outside [0, 1]");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_t1_v) && $stable(r_t5_v))
        else $error("pipeline moved during a stall");
endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] fx, fy, fz, px, py, pz, tx, ty, tz;
    } t_query;

    typedef struct {
        logic [31:0] qx, qy, qz, qw, dot;
        logic        degen;
    } t_orient;

    typedef struct {
        t_query  q;
        logic    known;
        t_orient r;
    } t_row;

    localparam int N_RANDOM = 1530;
    localparam int LATENCY  = 144;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    lac_in_if  in_ch ();
    lac_out_if out_ch ();

    look_at_shortest_arc_quaternion_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_orient orient_q[$];
    int      n_err = 0;
    bit      stim_done = 0;

    function automatic logic [63:0] root_round(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (n > r) r++;
        return r;
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint rnd_q30(longint x);
        logic [63:0] m;
        m = (mag(x) + (64'd1 << 29)) >> 30;
        return x < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Scale to a leading one at bit 29, then divide by the rounded length.
    function automatic bit make_unit(longint v[3], output longint u[3]);
        logic [63:0] m[3], mx, sum, len, q;
        int p;
        mx = 0;
        sum = 0;
        p = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (p < 63 && (mx >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            if (p > lac_pkg::MANT_MSB) m[i] >>= (p - lac_pkg::MANT_MSB);
            else m[i] <<= (lac_pkg::MANT_MSB - p);
            sum += m[i] * m[i];
        end
        len = root_round(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + len / 2) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic logic [31:0] quot_sat(longint a, logic [63:0] s);
        logic [63:0] q;
        longint v;
        q = ((mag(a) << 30) + s / 2) / s;
        v = a < 0 ? -longint'(q) : longint'(q);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_orient predict_orient(t_query q);
        t_orient r;
        longint f[3], d[3], uf[3], ud[3], ax[3], dt;
        logic [63:0] s;
        r = '{qx: 0, qy: 0, qz: 0, qw: lac_pkg::Q30_ONE, dot: lac_pkg::Q30_ONE, degen: 0};
        f = '{longint'($signed(q.fx)), longint'($signed(q.fy)),
              longint'($signed(q.fz))};
        d[0] = longint'($signed(q.tx)) - longint'($signed(q.px));
        d[1] = longint'($signed(q.ty)) - longint'($signed(q.py));
        d[2] = longint'($signed(q.tz)) - longint'($signed(q.pz));
        if (!make_unit(f, uf) || !make_unit(d, ud)) begin
            r.degen = 1;
            return r;
        end
        ax[0] = rnd_q30(uf[1] * ud[2] - uf[2] * ud[1]);
        ax[1] = rnd_q30(uf[2] * ud[0] - uf[0] * ud[2]);
        ax[2] = rnd_q30(uf[0] * ud[1] - uf[1] * ud[0]);
        dt = rnd_q30(uf[0] * ud[0] + uf[1] * ud[1] + uf[2] * ud[2]);
        if (dt > (64'sd1 << 30)) dt = 64'sd1 << 30;
        if (dt < -(64'sd1 << 30)) dt = -(64'sd1 << 30);
        r.dot = dt[31:0];
        s = root_round((((64'd1 << 30) + dt) * 2) << 30);
        if (s != 0) begin
            r.qx = quot_sat(ax[0], s);
            r.qy = quot_sat(ax[1], s);
            r.qz = quot_sat(ax[2], s);
            r.qw = 32'((s + 1) >> 1);
        end
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_err++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                           : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 3) - 1;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                           : -$urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_query q);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.forward_x <= q.fx; in_ch.forward_y <= q.fy; in_ch.forward_z <= q.fz;
        in_ch.src_x <= q.px; in_ch.src_y <= q.py; in_ch.src_z <= q.pz;
        in_ch.dest_x <= q.tx; in_ch.dest_y <= q.ty; in_ch.dest_z <= q.tz;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Accept words, compare against the oldest expected orientation.
    always @(posedge i_clk) begin
        t_orient w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (orient_q.size() == 0) begin
                report("unexpected word", out_ch.quat_x, 32'h0);
            end else begin
                w = orient_q.pop_front();
                if (out_ch.quat_x !== w.qx) report("quat_x", out_ch.quat_x, w.qx);
                if (out_ch.quat_y !== w.qy) report("quat_y", out_ch.quat_y, w.qy);
                if (out_ch.quat_z !== w.qz) report("quat_z", out_ch.quat_z, w.qz);
                if (out_ch.quat_w !== w.qw) report("quat_w", out_ch.quat_w, w.qw);
                if (out_ch.dot_product !== w.dot)
                    report("dot_product", out_ch.dot_product, w.dot);
                if (out_ch.degenerate !== w.degen)
                    report("degenerate", 32'(out_ch.degenerate), 32'(w.degen));
            end
        end
    end

    // Receiver stalls: long and short bursts, with stall-free stretches.
    initial begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
            g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    end

    function automatic t_row dir_row(logic [31:0] fx, fy, fz, tx, ty, tz,
                                     logic known = 0, t_orient r = '{default: 0});
        t_row w;
        w.q = '{fx, fy, fz, 0, 0, 0, tx, ty, tz};
        w.known = known;
        w.r = r;
        return w;
    endfunction

    initial begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        t_row   rows[$];
        t_query q;
        t_orient ident, ident_neg;
        ident = '{qx: 0, qy: 0, qz: 0, qw: lac_pkg::Q30_ONE, dot: lac_pkg::Q30_ONE,
                  degen: 1};
        ident_neg = '{qx: 0, qy: 0, qz: 0, qw: lac_pkg::Q30_ONE,
                      dot: lac_pkg::Q30_NEG_ONE, degen: 0};
        in_ch.valid = 1'b0;
        {in_ch.forward_x, in_ch.forward_y, in_ch.forward_z} = '0;
        {in_ch.src_x, in_ch.src_y, in_ch.src_z} = '0;
        {in_ch.dest_x, in_ch.dest_y, in_ch.dest_z} = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero forward, zero direction, opposite, aligned, perpendicular, extremes
        rows.push_back(dir_row(0, 0, 0, ONE, 0, 0, 1, ident));
        rows.push_back(dir_row(ONE, 0, 0, 0, 0, 0, 1, ident));
        rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 1, ident));
        rows.push_back(dir_row(ONE, 0, 0, -ONE, 0, 0, 1, ident_neg));
        rows.push_back(dir_row(0, 32'h8000_0000, 0, 0, 5, 0, 1, ident_neg));
        rows.push_back(dir_row(ONE, 0, 0, ONE, 0, 0));
        rows.push_back(dir_row(ONE, 0, 0, 0, ONE, 0));
        rows.push_back(dir_row(0, 0, ONE, 0, ONE, 0));
        rows.push_back(dir_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        rows.push_back(dir_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        rows.push_back(dir_row(1, 0, 0, -1, 1, 0));
        rows.push_back(dir_row(ONE, 1, 0, -ONE, 0, 0));   // nearly opposite
        rows.push_back(dir_row(32'h7FFF_FFFF, 3, 0, 32'h8000_0000, 0, 1));
        rows.push_back(dir_row(-1, -1, -1, 1, 1, 1));
        // 33-bit direction: target and source at opposite extremes, then a zero direction with a nonzero source
        begin
            t_row w;
            w = dir_row(ONE, ONE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
            w.q.px = 32'h8000_0000; w.q.py = 32'h7FFF_FFFF; w.q.pz = 32'h8000_0000;
            rows.push_back(w);
            w.q.px = 32'h7FFF_FFFF; w.q.tx = 32'h8000_0000;
            rows.push_back(w);
            w = dir_row(0, ONE, 0, 32'h1234, 32'h5678, 32'h9ABC);
            w.q.px = 32'h1234; w.q.py = 32'h5678; w.q.pz = 32'h9ABC;
            w.known = 1; w.r = ident;
            rows.push_back(w);
        end

        foreach (rows[i]) begin
            orient_q.push_back(rows[i].known ? rows[i].r : predict_orient(rows[i].q));
            send(rows[i].q);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            q = '{rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                  rnd_word(), rnd_word(), rnd_word(), rnd_word()};
            case ($urandom_range(0, 9))
                0: begin q.tx = q.px; q.ty = q.py; q.tz = q.pz; end
                1: {q.fx, q.fy, q.fz} = '0;
                2: begin  // near-opposite direction
                    q.px = 0; q.py = 0; q.pz = 0;
                    q.tx = -q.fx + $urandom_range(0, 2) - 1;
                    q.ty = -q.fy; q.tz = -q.fz;
                end
                3: begin  // near-aligned direction
                    q.px = 0; q.py = 0; q.pz = 0;
                    q.tx = q.fx; q.ty = q.fy + $urandom_range(0, 2) - 1; q.tz = q.fz;
                end
                default: ;
            endcase
            orient_q.push_back(predict_orient(q));
            send(q);
        end
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (orient_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_err == 0) $display("[look_at_shortest_arc_quaternion_core] OK");
        else $display("[look_at_shortest_arc_quaternion_core] ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("[look_at_shortest_arc_quaternion_core] ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/lac_pkg.sv
rtl/lac_if.sv
rtl/lac_isqrt.sv
rtl/lac_div.sv
rtl/lac_norm.sv
rtl/look_at_shortest_arc_quaternion_core.sv
verif/tb.sv
